// ===== src/dgpc_pkg.sv =====
// Package for the dual gated pulse counter: word types, command and source codes.
// Used by every module of the block; depends on nothing else.
package dgpc_pkg;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd150;

    typedef enum logic [3:0] {
        CMD_RESET_ALL  = 4'd0,
        CMD_RESET_ONE  = 4'd1,
        CMD_RESET_TWO  = 4'd2,
        CMD_READ_ONE   = 4'd3,
        CMD_READ_TWO   = 4'd4,
        CMD_ENABLE_ONE = 4'd5,
        CMD_ENABLE_TWO = 4'd6,
        CMD_DISABLE_ONE = 4'd7,
        CMD_DISABLE_TWO = 4'd8
    } cmd_code_t;

    localparam logic [1:0] SRC_ALWAYS = 2'd0;
    localparam logic [1:0] SRC_REMOTE = 2'd1;
    localparam logic [1:0] SRC_GATE   = 2'd2;
    localparam logic [1:0] SRC_HOLD   = 2'd3;

    typedef struct packed {
        logic       opcode;
        logic [3:0] command_code;
        logic       pulse_one;
        logic       pulse_two;
        logic       gate_one;
        logic       gate_two;
        logic [1:0] source_one;
        logic [1:0] source_two;
        logic       button_one;
        logic       button_two;
        logic       ext_reset_one;
        logic       ext_reset_two;
    } dgpc_in_t;

    typedef struct packed {
        logic [31:0] count_value;
        logic        done_ok;
        logic        enable_out_one;
        logic        enable_out_two;
    } dgpc_out_t;

    // Control from the top level to one channel for the word being processed.
    typedef struct packed {
        logic       step;
        logic       tick;
        logic       pulse;
        logic       gate;
        logic [1:0] source;
        logic       button;
        logic       ext_reset;
        logic       clear;
        logic       remote_wr;
        logic       remote_val;
    } dgpc_chan_ctl_t;

    // Status from one channel back to the top level.
    typedef struct packed {
        logic [31:0] count_low;
        logic        enable_next;
        logic        is_remote;
    } dgpc_chan_sts_t;

endpackage

// ===== src/dgpc_channel.sv =====
// One counter channel: count, enable, remote flag, last seen source and push-button timing.
// Depends on dgpc_pkg.
module dgpc_channel
    import dgpc_pkg::*;
#(
    parameter int COUNT_BITS = 32
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  dgpc_chan_ctl_t ctl,
    input  logic [31:0]    tick_now,
    input  logic [15:0]    debounce,
    output dgpc_chan_sts_t sts
);

    logic [COUNT_BITS-1:0] count_reg, count_next, count_inc;
    logic                  remote_reg, remote_next;
    logic                  enable_reg, enable_next, en_pick;
    logic [1:0]            seen_reg, seen_next;
    logic [31:0]           last_reg, last_next, last_eff, gap;
    logic                  press;

    always_comb
    begin
        case (ctl.source)
            SRC_ALWAYS: en_pick = 1'b1;
            SRC_REMOTE: en_pick = remote_reg;
            SRC_GATE:   en_pick = ctl.gate;
            default:    en_pick = enable_reg;
        endcase
    end

    // A stored press time ahead of the tick counter means the counter has wrapped.
    assign last_eff  = (last_reg > tick_now) ? 32'd0 : last_reg;
    assign gap       = tick_now - last_eff;
    assign press     = ctl.button && (gap > {16'd0, debounce});
    assign count_inc = count_reg + {{(COUNT_BITS-1){1'b0}}, 1'b1};

    always_comb
    begin
        count_next  = count_reg;
        remote_next = remote_reg;
        enable_next = enable_reg;
        seen_next   = seen_reg;
        last_next   = last_reg;
        if (ctl.tick)
        begin
            seen_next   = ctl.source;
            enable_next = en_pick;
            if (en_pick && ctl.pulse)
            begin
                count_next = count_inc;
            end
            if (ctl.button)
            begin
                last_next = press ? tick_now : last_eff;
            end
            if (press || ctl.ext_reset)
            begin
                count_next = '0;
            end
        end
        else
        begin
            if (ctl.clear)
            begin
                count_next = '0;
            end
            if (ctl.remote_wr && (seen_reg == SRC_REMOTE))
            begin
                remote_next = ctl.remote_val;
                enable_next = ctl.remote_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            remote_reg <= 1'b0;
            enable_reg <= 1'b0;
            seen_reg   <= SRC_ALWAYS;
            last_reg   <= '0;
        end
        else if (ctl.step)
        begin
            count_reg  <= count_next;
            remote_reg <= remote_next;
            enable_reg <= enable_next;
            seen_reg   <= seen_next;
            last_reg   <= last_next;
        end
    end

    generate
        if (COUNT_BITS >= 32)
        begin : g_wide
            assign sts.count_low = count_reg[31:0];
        end
        else
        begin : g_narrow
            assign sts.count_low = {{(32-COUNT_BITS){1'b0}}, count_reg};
        end
    endgenerate

    assign sts.enable_next = enable_next;
    assign sts.is_remote   = (seen_reg == SRC_REMOTE);

endmodule

// ===== src/dual_gated_pulse_counter_unit.sv =====
// Top level of the dual gated pulse counter: input register, word decode, two channels
// and the result register. Depends on dgpc_pkg and dgpc_channel.
//
// Usage. Each input word is either a tick, carrying the pin samples of one time step
// (pulses, gate levels, source switches, push-buttons and coaxial resets), or a command
// that resets, reads, or remotely enables or disables a channel. Every word yields
// exactly one result word with the read value, the command status and both enables.
// Both channels use valid and ready; a word moves when valid and ready are high together.
// The debounce register is written through cfg_wr_en and cfg_wr_data at any edge with the
// enable high, and should only be written while the block is idle.
// An accepted word is held in the input register, where it is decoded and applied to the
// counter state, and its result is then loaded into the result register, which drives
// out_valid; that step is taken as soon as the output is free.
// Throughput: one word per cycle unless stalled. The state update is a single pass
// through the channel logic, so each word sees everything the previous one left behind.
// When the receiver stalls the result register holds its word, the input register fills,
// and in_ready falls only when both are occupied; nothing is lost or repeated.
// Reset clears both counters, enables, remote flags, the tick clock and the press times,
// and restores a debounce distance of 150 ticks.
module dual_gated_pulse_counter_unit
    import dgpc_pkg::*;
#(
    parameter int COUNT_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  dgpc_in_t    in_word,
    output logic        out_valid,
    input  logic        out_ready,
    output dgpc_out_t   out_word,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic           hold_valid_reg;
    dgpc_in_t       hold_word_reg;
    logic           out_valid_reg;
    dgpc_out_t      out_word_reg, out_word_next;
    logic [15:0]    debounce_reg;
    logic [31:0]    tick_time_reg, tick_time_next;
    logic           advance;
    logic           is_tick;
    dgpc_chan_ctl_t ctl_one, ctl_two;
    dgpc_chan_sts_t sts_one, sts_two;
    logic           ok;
    logic [31:0]    value;

    // The held word is processed when the result register is free or being emptied.
    assign advance  = hold_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !hold_valid_reg || advance;
    assign is_tick  = (hold_word_reg.opcode == OP_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hold_word_reg <= in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_wr_en)
        begin
            debounce_reg <= cfg_wr_data;
        end
    end

    // The tick clock advances before the push-button test uses it.
    assign tick_time_next = tick_time_reg + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_time_reg <= '0;
        end
        else if (advance && is_tick)
        begin
            tick_time_reg <= tick_time_next;
        end
    end

    // Command decode. Reads take the count as it stands; unknown codes change nothing.
    always_comb
    begin
        ctl_one            = '0;
        ctl_two            = '0;
        ctl_one.step       = advance;
        ctl_two.step       = advance;
        ctl_one.tick       = is_tick;
        ctl_two.tick       = is_tick;
        ctl_one.pulse      = hold_word_reg.pulse_one;
        ctl_two.pulse      = hold_word_reg.pulse_two;
        ctl_one.gate       = hold_word_reg.gate_one;
        ctl_two.gate       = hold_word_reg.gate_two;
        ctl_one.source     = hold_word_reg.source_one;
        ctl_two.source     = hold_word_reg.source_two;
        ctl_one.button     = hold_word_reg.button_one;
        ctl_two.button     = hold_word_reg.button_two;
        ctl_one.ext_reset  = hold_word_reg.ext_reset_one;
        ctl_two.ext_reset  = hold_word_reg.ext_reset_two;
        ok                 = 1'b0;
        value              = '0;
        if (!is_tick)
        begin
            case (hold_word_reg.command_code)
                CMD_RESET_ALL:
                begin
                    ctl_one.clear = 1'b1;
                    ctl_two.clear = 1'b1;
                    ok            = 1'b1;
                end
                CMD_RESET_ONE:
                begin
                    ctl_one.clear = 1'b1;
                    ok            = 1'b1;
                end
                CMD_RESET_TWO:
                begin
                    ctl_two.clear = 1'b1;
                    ok            = 1'b1;
                end
                CMD_READ_ONE:
                begin
                    value = sts_one.count_low;
                    ok    = 1'b1;
                end
                CMD_READ_TWO:
                begin
                    value = sts_two.count_low;
                    ok    = 1'b1;
                end
                CMD_ENABLE_ONE:
                begin
                    ctl_one.remote_wr  = 1'b1;
                    ctl_one.remote_val = 1'b1;
                    ok                 = sts_one.is_remote;
                end
                CMD_ENABLE_TWO:
                begin
                    ctl_two.remote_wr  = 1'b1;
                    ctl_two.remote_val = 1'b1;
                    ok                 = sts_two.is_remote;
                end
                CMD_DISABLE_ONE:
                begin
                    ctl_one.remote_wr = 1'b1;
                    ok                = sts_one.is_remote;
                end
                CMD_DISABLE_TWO:
                begin
                    ctl_two.remote_wr = 1'b1;
                    ok                = sts_two.is_remote;
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase
        end
    end

    dgpc_channel #(
        .COUNT_BITS (COUNT_BITS)
    ) u_chan_one (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_one),
        .tick_now (tick_time_next),
        .debounce (debounce_reg),
        .sts      (sts_one)
    );

    dgpc_channel #(
        .COUNT_BITS (COUNT_BITS)
    ) u_chan_two (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_two),
        .tick_now (tick_time_next),
        .debounce (debounce_reg),
        .sts      (sts_two)
    );

    assign out_word_next.count_value    = value;
    assign out_word_next.done_ok        = ok;
    assign out_word_next.enable_out_one = sts_one.enable_next;
    assign out_word_next.enable_out_two = sts_two.enable_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= hold_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ===== src/dgpc_checker.sv =====
// Port-level checks for the dual gated pulse counter, bound to the top level.
// Depends on dgpc_pkg and dual_gated_pulse_counter_unit.
module dgpc_checker
    import dgpc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input dgpc_out_t out_word
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // With the result register empty the block always takes a word.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused while result register empty");

    // A word taken with the output empty shows its result once it has passed the input and result registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |-> ##2 out_valid)
        else $error("result missing after accepted word");

    // Only a successful read carries a non-zero value.
    a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word.count_value != 32'd0) |-> out_word.done_ok)
        else $error("count value without accepted command");

    // No result is shown in the first cycle out of reset.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid straight after reset");

endmodule

bind dual_gated_pulse_counter_unit dgpc_checker u_dgpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);
